### rtl/i2cbs_pkg.sv
// shared types and constants for the i2c master bit sequencer
// used by i2cbs_cfg, i2cbs_core and i2c_master_bit_sequencer; no dependencies
package i2cbs_pkg;

  localparam int DATA_BITS = 8;
  localparam int HP_W      = 16;
  localparam int POLL_W    = 8;
  localparam int PH_W      = 5;
  localparam int BIT_W     = 4;
  localparam int ADDR_W    = 3;

  localparam logic [HP_W-1:0]   HALF_PERIOD_RST = 16'd150;
  localparam logic [POLL_W-1:0] POLL_LIMIT_RST  = 8'd249;

  // register indexes
  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_POLL_LIMIT  = 1'b1;

  // commands
  localparam logic [2:0] MODE_NONE  = 3'd0;
  localparam logic [2:0] MODE_START = 3'd1;
  localparam logic [2:0] MODE_STOP  = 3'd2;
  localparam logic [2:0] MODE_WRITE = 3'd3;
  localparam logic [2:0] MODE_WACK  = 3'd4;
  localparam logic [2:0] MODE_READ  = 3'd5;
  localparam logic [2:0] MODE_ACK   = 3'd6;
  localparam logic [2:0] MODE_NACK  = 3'd7;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_ACK   = 2'd1;
  localparam logic [1:0] ST_START_FL = 2'd2;

  // sequencer phases
  localparam logic [PH_W-1:0] PH_IDLE        = 5'd0;
  localparam logic [PH_W-1:0] PH_ST_SETTLE   = 5'd1;
  localparam logic [PH_W-1:0] PH_ST_POLL_HI  = 5'd2;
  localparam logic [PH_W-1:0] PH_ST_LOW_WAIT = 5'd3;
  localparam logic [PH_W-1:0] PH_ST_POLL_LO  = 5'd4;
  localparam logic [PH_W-1:0] PH_FIN_WAIT    = 5'd5;
  localparam logic [PH_W-1:0] PH_SP_A        = 5'd6;
  localparam logic [PH_W-1:0] PH_SP_B        = 5'd7;
  localparam logic [PH_W-1:0] PH_AK_A        = 5'd8;
  localparam logic [PH_W-1:0] PH_AK_B        = 5'd9;
  localparam logic [PH_W-1:0] PH_AK_C        = 5'd10;
  localparam logic [PH_W-1:0] PH_WA_A        = 5'd11;
  localparam logic [PH_W-1:0] PH_WA_B        = 5'd12;
  localparam logic [PH_W-1:0] PH_WA_C        = 5'd13;
  localparam logic [PH_W-1:0] PH_W_LOW       = 5'd14;
  localparam logic [PH_W-1:0] PH_W_HIGH      = 5'd15;
  localparam logic [PH_W-1:0] PH_R_SETUP     = 5'd16;
  localparam logic [PH_W-1:0] PH_R_HIGH      = 5'd17;
  localparam logic [PH_W-1:0] PH_R_LOW       = 5'd18;

  typedef struct packed {
    logic [HP_W-1:0]   half_period;
    logic [POLL_W-1:0] poll_limit;
  } cfg_t;

  typedef struct packed {
    logic                 scl;
    logic                 sda;
    logic                 busy;
    logic                 done;
    logic [DATA_BITS-1:0] rdata;
    logic [1:0]           status;
  } res_t;

endpackage

### rtl/i2c_master_bit_sequencer.sv
// top level of the i2c master bit sequencer: input register, step core, result register
// depends on i2cbs_pkg, i2cbs_cfg and i2cbs_core
//
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_stall    | mode, write_data, sda_in
//  out_    | output    | out_valid / out_stall  | scl, sda, busy, done, read data, status
//  cfg     | input     | psel/penable/pready    | half_period_ticks, poll_limit
//
// one tick item per clock while the input does not stall; each item waits in the input
// register until it can advance and its result is then offered from the result register
// the input stalls only while both registers hold items and out_stall is high
// reset is synchronous and active low; no clearing pass is needed
module i2c_master_bit_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      in_mode,
  input  logic [i2cbs_pkg::DATA_BITS-1:0] in_write_data,
  input  logic                            in_sda_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_scl_out,
  output logic                            out_sda_out,
  output logic                            out_busy_res,
  output logic                            out_done_res,
  output logic [i2cbs_pkg::DATA_BITS-1:0] out_read_data,
  output logic [1:0]                      out_status,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [i2cbs_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  i2cbs_pkg::cfg_t                 cfg;
  i2cbs_pkg::res_t                 res;
  i2cbs_pkg::res_t                 res_r;
  logic                            in_vld_r, out_vld_r;
  logic [2:0]                      mode_r;
  logic [i2cbs_pkg::DATA_BITS-1:0] wdata_r;
  logic                            sda_in_r;
  logic                            advance;

  i2cbs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  i2cbs_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .mode    (mode_r),
    .wdata   (wdata_r),
    .sda_in  (sda_in_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      mode_r   <= in_mode;
      wdata_r  <= in_write_data;
      sda_in_r <= in_sda_in;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_scl_out   = res_r.scl;
  assign out_sda_out   = res_r.sda;
  assign out_busy_res  = res_r.busy;
  assign out_done_res  = res_r.done;
  assign out_read_data = res_r.rdata;
  assign out_status    = res_r.status;

  // a finished command leaves the sequencer idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_done_res |-> !out_busy_res)
    else $error("done reported while still busy");

  // status never takes the unused code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_status != 2'd3))
    else $error("status holds an undefined code");

  // the input side only stalls while it holds an item that cannot advance
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && out_vld_r && out_stall))
    else $error("input stalled without a blocked result");

  // a step always yields a valid result on the next cycle
  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("stepped item produced no result");

endmodule

### rtl/i2cbs_cfg.sv
// apb-style configuration registers: half period and start poll limit
// depends on i2cbs_pkg
module i2cbs_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [i2cbs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output i2cbs_pkg::cfg_t              cfg
);

  logic [i2cbs_pkg::HP_W-1:0]   half_r;
  logic [i2cbs_pkg::POLL_W-1:0] poll_r;
  logic                         wr_en;
  logic                         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= i2cbs_pkg::HALF_PERIOD_RST;
      poll_r <= i2cbs_pkg::POLL_LIMIT_RST;
    end else if (wr_en) begin
      if (idx == i2cbs_pkg::REG_HALF_PERIOD) begin
        half_r <= pwdata[i2cbs_pkg::HP_W-1:0];
      end else begin
        poll_r <= pwdata[i2cbs_pkg::POLL_W-1:0];
      end
    end
  end

  always_comb begin
    if (idx == i2cbs_pkg::REG_HALF_PERIOD) begin
      prdata = {{(32-i2cbs_pkg::HP_W){1'b0}}, half_r};
    end else begin
      prdata = {{(32-i2cbs_pkg::POLL_W){1'b0}}, poll_r};
    end
  end

  assign cfg.half_period = half_r;
  assign cfg.poll_limit  = poll_r;

endmodule

### rtl/i2cbs_core.sv
// line sequencer state and one-tick step logic
// depends on i2cbs_pkg
module i2cbs_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step_en,
  input  logic [2:0]                      mode,
  input  logic [i2cbs_pkg::DATA_BITS-1:0] wdata,
  input  logic                            sda_in,
  input  i2cbs_pkg::cfg_t                 cfg,
  output i2cbs_pkg::res_t                 res
);

  logic [i2cbs_pkg::PH_W-1:0]      ph_r, ph_nxt;
  logic [i2cbs_pkg::HP_W-1:0]      dly_r, dly_nxt;
  logic [i2cbs_pkg::POLL_W-1:0]    poll_r, poll_nxt, poll_inc;
  logic [i2cbs_pkg::BIT_W-1:0]     bit_r, bit_nxt, bit_inc;
  logic [i2cbs_pkg::DATA_BITS-1:0] shf_r, shf_nxt, rbyte_r, rbyte_nxt;
  logic                            scl_r, scl_nxt, sda_r, sda_nxt;
  logic [1:0]                      stat_r, stat_nxt;
  logic                            done_nxt;
  logic                            waited;

  assign waited   = (dly_r <= {{(i2cbs_pkg::HP_W-1){1'b0}}, 1'b1});
  assign poll_inc = poll_r + 1'b1;
  assign bit_inc  = bit_r + 1'b1;

  always_comb begin
    ph_nxt    = ph_r;
    dly_nxt   = dly_r;
    poll_nxt  = poll_r;
    bit_nxt   = bit_r;
    shf_nxt   = shf_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    stat_nxt  = stat_r;
    rbyte_nxt = rbyte_r;
    done_nxt  = 1'b0;
    // count down the half-period delay in every waiting phase
    if (ph_r != i2cbs_pkg::PH_IDLE && ph_r != i2cbs_pkg::PH_ST_POLL_HI &&
        ph_r != i2cbs_pkg::PH_ST_POLL_LO) begin
      dly_nxt = waited ? '0 : dly_r - 1'b1;
    end
    case (ph_r)
      i2cbs_pkg::PH_IDLE: begin
        if (mode != i2cbs_pkg::MODE_NONE) begin
          bit_nxt  = '0;
          poll_nxt = '0;
          dly_nxt  = cfg.half_period;
          case (mode)
            i2cbs_pkg::MODE_START: begin
              sda_nxt = 1'b1;
              scl_nxt = 1'b1;
              ph_nxt  = i2cbs_pkg::PH_ST_SETTLE;
            end
            i2cbs_pkg::MODE_STOP: begin
              sda_nxt = 1'b0;
              ph_nxt  = i2cbs_pkg::PH_SP_A;
            end
            i2cbs_pkg::MODE_WRITE: begin
              sda_nxt = wdata[i2cbs_pkg::DATA_BITS-1];
              shf_nxt = {wdata[i2cbs_pkg::DATA_BITS-2:0], 1'b0};
              ph_nxt  = i2cbs_pkg::PH_W_LOW;
            end
            i2cbs_pkg::MODE_WACK: begin
              sda_nxt = 1'b1;
              ph_nxt  = i2cbs_pkg::PH_WA_A;
            end
            i2cbs_pkg::MODE_READ: begin
              sda_nxt = 1'b1;
              shf_nxt = '0;
              ph_nxt  = i2cbs_pkg::PH_R_SETUP;
            end
            i2cbs_pkg::MODE_ACK: begin
              sda_nxt = 1'b0;
              ph_nxt  = i2cbs_pkg::PH_AK_A;
            end
            default: begin
              sda_nxt = 1'b1;
              ph_nxt  = i2cbs_pkg::PH_AK_A;
            end
          endcase
        end
      end
      i2cbs_pkg::PH_ST_SETTLE: begin
        if (waited) begin
          poll_nxt = '0;
          ph_nxt   = i2cbs_pkg::PH_ST_POLL_HI;
        end
      end
      i2cbs_pkg::PH_ST_POLL_HI: begin
        if (sda_in) begin
          sda_nxt = 1'b0;
          dly_nxt = cfg.half_period;
          ph_nxt  = i2cbs_pkg::PH_ST_LOW_WAIT;
        end else begin
          poll_nxt = poll_inc;
          if (poll_inc >= cfg.poll_limit) begin
            ph_nxt   = i2cbs_pkg::PH_IDLE;
            stat_nxt = i2cbs_pkg::ST_START_FL;
            done_nxt = 1'b1;
          end
        end
      end
      i2cbs_pkg::PH_ST_LOW_WAIT: begin
        if (waited) begin
          poll_nxt = '0;
          ph_nxt   = i2cbs_pkg::PH_ST_POLL_LO;
        end
      end
      i2cbs_pkg::PH_ST_POLL_LO: begin
        if (!sda_in) begin
          sda_nxt = 1'b0;
          scl_nxt = 1'b0;
          dly_nxt = cfg.half_period;
          ph_nxt  = i2cbs_pkg::PH_FIN_WAIT;
        end else begin
          poll_nxt = poll_inc;
          if (poll_inc >= cfg.poll_limit) begin
            ph_nxt   = i2cbs_pkg::PH_IDLE;
            stat_nxt = i2cbs_pkg::ST_START_FL;
            done_nxt = 1'b1;
          end
        end
      end
      i2cbs_pkg::PH_FIN_WAIT: begin
        if (waited) begin
          ph_nxt   = i2cbs_pkg::PH_IDLE;
          stat_nxt = i2cbs_pkg::ST_OK;
          done_nxt = 1'b1;
        end
      end
      i2cbs_pkg::PH_SP_A: begin
        if (waited) begin
          scl_nxt = 1'b1;
          dly_nxt = cfg.half_period;
          ph_nxt  = i2cbs_pkg::PH_SP_B;
        end
      end
      i2cbs_pkg::PH_SP_B: begin
        if (waited) begin
          sda_nxt = 1'b1;
          dly_nxt = cfg.half_period;
          ph_nxt  = i2cbs_pkg::PH_FIN_WAIT;
        end
      end
      i2cbs_pkg::PH_AK_A: begin
        if (waited) begin
          scl_nxt = 1'b1;
          dly_nxt = cfg.half_period;
          ph_nxt  = i2cbs_pkg::PH_AK_B;
        end
      end
      i2cbs_pkg::PH_AK_B: begin
        if (waited) begin
          scl_nxt = 1'b0;
          dly_nxt = cfg.half_period;
          ph_nxt  = i2cbs_pkg::PH_AK_C;
        end
      end
      i2cbs_pkg::PH_AK_C: begin
        if (waited) begin
          sda_nxt = 1'b0;
          dly_nxt = cfg.half_period;
          ph_nxt  = i2cbs_pkg::PH_FIN_WAIT;
        end
      end
      i2cbs_pkg::PH_WA_A: begin
        if (waited) begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
          dly_nxt = cfg.half_period;
          ph_nxt  = i2cbs_pkg::PH_WA_B;
        end
      end
      i2cbs_pkg::PH_WA_B: begin
        if (waited) begin
          scl_nxt = 1'b0;
          if (sda_in) begin
            dly_nxt = cfg.half_period;
            ph_nxt  = i2cbs_pkg::PH_WA_C;
          end else begin
            ph_nxt   = i2cbs_pkg::PH_IDLE;
            stat_nxt = i2cbs_pkg::ST_OK;
            done_nxt = 1'b1;
          end
        end
      end
      i2cbs_pkg::PH_WA_C: begin
        if (waited) begin
          ph_nxt   = i2cbs_pkg::PH_IDLE;
          stat_nxt = i2cbs_pkg::ST_NO_ACK;
          done_nxt = 1'b1;
        end
      end
      i2cbs_pkg::PH_W_LOW: begin
        if (waited) begin
          scl_nxt = 1'b1;
          dly_nxt = cfg.half_period;
          ph_nxt  = i2cbs_pkg::PH_W_HIGH;
        end
      end
      i2cbs_pkg::PH_W_HIGH: begin
        if (waited) begin
          scl_nxt = 1'b0;
          bit_nxt = bit_inc;
          if (bit_inc >= i2cbs_pkg::BIT_W'(i2cbs_pkg::DATA_BITS)) begin
            ph_nxt   = i2cbs_pkg::PH_IDLE;
            stat_nxt = i2cbs_pkg::ST_OK;
            done_nxt = 1'b1;
          end else begin
            sda_nxt = shf_r[i2cbs_pkg::DATA_BITS-1];
            shf_nxt = {shf_r[i2cbs_pkg::DATA_BITS-2:0], 1'b0};
            dly_nxt = cfg.half_period;
            ph_nxt  = i2cbs_pkg::PH_W_LOW;
          end
        end
      end
      i2cbs_pkg::PH_R_SETUP: begin
        if (waited) begin
          scl_nxt = 1'b1;
          dly_nxt = cfg.half_period;
          ph_nxt  = i2cbs_pkg::PH_R_HIGH;
        end
      end
      i2cbs_pkg::PH_R_HIGH: begin
        if (waited) begin
          shf_nxt = {shf_r[i2cbs_pkg::DATA_BITS-2:0], sda_in};
          scl_nxt = 1'b0;
          bit_nxt = bit_inc;
          dly_nxt = cfg.half_period;
          ph_nxt  = i2cbs_pkg::PH_R_LOW;
        end
      end
      i2cbs_pkg::PH_R_LOW: begin
        if (waited) begin
          if (bit_r >= i2cbs_pkg::BIT_W'(i2cbs_pkg::DATA_BITS)) begin
            rbyte_nxt = shf_r;
            ph_nxt    = i2cbs_pkg::PH_IDLE;
            stat_nxt  = i2cbs_pkg::ST_OK;
            done_nxt  = 1'b1;
          end else begin
            scl_nxt = 1'b1;
            dly_nxt = cfg.half_period;
            ph_nxt  = i2cbs_pkg::PH_R_HIGH;
          end
        end
      end
      default: begin
        ph_nxt = i2cbs_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= i2cbs_pkg::PH_IDLE;
      dly_r   <= '0;
      poll_r  <= '0;
      bit_r   <= '0;
      shf_r   <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      stat_r  <= i2cbs_pkg::ST_OK;
      rbyte_r <= '0;
    end else if (step_en) begin
      ph_r    <= ph_nxt;
      dly_r   <= dly_nxt;
      poll_r  <= poll_nxt;
      bit_r   <= bit_nxt;
      shf_r   <= shf_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      stat_r  <= stat_nxt;
      rbyte_r <= rbyte_nxt;
    end
  end

  assign res.scl    = scl_nxt;
  assign res.sda    = sda_nxt;
  assign res.busy   = (ph_nxt != i2cbs_pkg::PH_IDLE);
  assign res.done   = done_nxt;
  assign res.rdata  = rbyte_nxt;
  assign res.status = stat_nxt;

endmodule

### dv/i2c_line_checker.sv
// line checker for i2c_master_bit_sequencer: predicts every result from the accepted items
// and compares it field by field, also checks register readback; depends on i2cbs_pkg only
`timescale 1ns / 100ps

module i2c_line_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [2:0]                      in_mode,
  input  logic [i2cbs_pkg::DATA_BITS-1:0] in_write_data,
  input  logic                            in_sda_in,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            out_scl_out,
  input  logic                            out_sda_out,
  input  logic                            out_busy_res,
  input  logic                            out_done_res,
  input  logic [i2cbs_pkg::DATA_BITS-1:0] out_read_data,
  input  logic [1:0]                      out_status,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [i2cbs_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  input  logic [31:0]                     prdata,
  input  logic                            pready,
  output int                              mismatches,
  output int                              pending_results
);
  import i2cbs_pkg::*;

  logic [HP_W-1:0]      half_period;
  logic [POLL_W-1:0]    poll_max;
  logic [PH_W-1:0]      phase_q;
  logic [HP_W-1:0]      delay_left;
  logic [POLL_W-1:0]    polls;
  logic [BIT_W-1:0]     bit_idx;
  logic [DATA_BITS-1:0] shifter;
  logic                 scl_q;
  logic                 sda_q;
  logic                 done_q;
  logic [1:0]           status_q;
  logic [DATA_BITS-1:0] rx_byte;
  res_t                 want;
  res_t                 expected_lines[$];

  function automatic void arm_delay(input logic [PH_W-1:0] next);
    delay_left = half_period;
    phase_q    = next;
  endfunction

  function automatic logic delay_over();
    if (delay_left > 1) begin
      delay_left = delay_left - 1'b1;
      return 1'b0;
    end
    delay_left = '0;
    return 1'b1;
  endfunction

  function automatic void end_command(input logic [1:0] st);
    phase_q  = PH_IDLE;
    status_q = st;
    done_q   = 1'b1;
  endfunction

  function automatic void next_tx_bit();
    sda_q   = shifter[DATA_BITS-1];
    shifter = shifter << 1;
  endfunction

  // advance the line sequencer by one tick
  function automatic res_t line_tick(input logic [2:0] mode, input logic [DATA_BITS-1:0] wd,
                                     input logic sda);
    res_t r;
    done_q = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (mode != MODE_NONE) begin
          bit_idx = '0;
          polls   = '0;
          case (mode)
            MODE_START: begin
              sda_q = 1'b1;
              scl_q = 1'b1;
              arm_delay(PH_ST_SETTLE);
            end
            MODE_STOP: begin
              sda_q = 1'b0;
              arm_delay(PH_SP_A);
            end
            MODE_WRITE: begin
              shifter = wd;
              next_tx_bit();
              arm_delay(PH_W_LOW);
            end
            MODE_WACK: begin
              sda_q = 1'b1;
              arm_delay(PH_WA_A);
            end
            MODE_READ: begin
              sda_q   = 1'b1;
              shifter = '0;
              arm_delay(PH_R_SETUP);
            end
            MODE_ACK: begin
              sda_q = 1'b0;
              arm_delay(PH_AK_A);
            end
            default: begin
              sda_q = 1'b1;
              arm_delay(PH_AK_A);
            end
          endcase
        end
      end
      PH_ST_SETTLE: begin
        if (delay_over()) begin
          polls   = '0;
          phase_q = PH_ST_POLL_HI;
        end
      end
      PH_ST_POLL_HI: begin
        if (sda) begin
          sda_q = 1'b0;
          arm_delay(PH_ST_LOW_WAIT);
        end else begin
          polls = polls + 1'b1;
          if (polls >= poll_max) end_command(ST_START_FL);
        end
      end
      PH_ST_LOW_WAIT: begin
        if (delay_over()) begin
          polls   = '0;
          phase_q = PH_ST_POLL_LO;
        end
      end
      PH_ST_POLL_LO: begin
        if (!sda) begin
          sda_q = 1'b0;
          scl_q = 1'b0;
          arm_delay(PH_FIN_WAIT);
        end else begin
          polls = polls + 1'b1;
          if (polls >= poll_max) end_command(ST_START_FL);
        end
      end
      PH_FIN_WAIT: begin
        if (delay_over()) end_command(ST_OK);
      end
      PH_SP_A: begin
        if (delay_over()) begin
          scl_q = 1'b1;
          arm_delay(PH_SP_B);
        end
      end
      PH_SP_B: begin
        if (delay_over()) begin
          sda_q = 1'b1;
          arm_delay(PH_FIN_WAIT);
        end
      end
      PH_AK_A: begin
        if (delay_over()) begin
          scl_q = 1'b1;
          arm_delay(PH_AK_B);
        end
      end
      PH_AK_B: begin
        if (delay_over()) begin
          scl_q = 1'b0;
          arm_delay(PH_AK_C);
        end
      end
      PH_AK_C: begin
        if (delay_over()) begin
          sda_q = 1'b0;
          arm_delay(PH_FIN_WAIT);
        end
      end
      PH_WA_A: begin
        if (delay_over()) begin
          scl_q = 1'b1;
          sda_q = 1'b1;
          arm_delay(PH_WA_B);
        end
      end
      PH_WA_B: begin
        if (delay_over()) begin
          scl_q = 1'b0;
          if (sda) arm_delay(PH_WA_C);
          else end_command(ST_OK);
        end
      end
      PH_WA_C: begin
        if (delay_over()) end_command(ST_NO_ACK);
      end
      PH_W_LOW: begin
        if (delay_over()) begin
          scl_q = 1'b1;
          arm_delay(PH_W_HIGH);
        end
      end
      PH_W_HIGH: begin
        if (delay_over()) begin
          scl_q   = 1'b0;
          bit_idx = bit_idx + 1'b1;
          if (bit_idx >= BIT_W'(DATA_BITS)) begin
            end_command(ST_OK);
          end else begin
            next_tx_bit();
            arm_delay(PH_W_LOW);
          end
        end
      end
      PH_R_SETUP: begin
        if (delay_over()) begin
          scl_q = 1'b1;
          arm_delay(PH_R_HIGH);
        end
      end
      PH_R_HIGH: begin
        if (delay_over()) begin
          shifter = {shifter[DATA_BITS-2:0], sda};
          scl_q   = 1'b0;
          bit_idx = bit_idx + 1'b1;
          arm_delay(PH_R_LOW);
        end
      end
      PH_R_LOW: begin
        if (delay_over()) begin
          if (bit_idx >= BIT_W'(DATA_BITS)) begin
            rx_byte = shifter;
            end_command(ST_OK);
          end else begin
            scl_q = 1'b1;
            arm_delay(PH_R_HIGH);
          end
        end
      end
      default: begin
        phase_q = PH_IDLE;
      end
    endcase
    r.scl    = scl_q;
    r.sda    = sda_q;
    r.busy   = (phase_q != PH_IDLE);
    r.done   = done_q;
    r.rdata  = rx_byte;
    r.status = status_q;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      if (mismatches <= 200)
        $display("%0t %s mismatch: expected %0h, actual %0h", $time, what, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      half_period = HALF_PERIOD_RST;
      poll_max    = POLL_LIMIT_RST;
      phase_q     = PH_IDLE;
      delay_left  = '0;
      polls       = '0;
      bit_idx     = '0;
      shifter     = '0;
      scl_q       = 1'b1;
      sda_q       = 1'b1;
      done_q      = 1'b0;
      status_q    = ST_OK;
      rx_byte     = '0;
      expected_lines.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_HALF_PERIOD) half_period = pwdata[HP_W-1:0];
          else poll_max = pwdata[POLL_W-1:0];
        end else if (paddr[2] == REG_HALF_PERIOD) begin
          check_field("half_period_ticks readback", 32'(half_period), prdata);
        end else begin
          check_field("poll_limit readback", 32'(poll_max), prdata);
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_lines.size() == 0) begin
          mismatches++;
          if (mismatches <= 200) $display("%0t result arrived with no tick pending", $time);
        end else begin
          want = expected_lines.pop_front();
          check_field("scl_out", 32'(want.scl), 32'(out_scl_out));
          check_field("sda_out", 32'(want.sda), 32'(out_sda_out));
          check_field("busy_res", 32'(want.busy), 32'(out_busy_res));
          check_field("done_res", 32'(want.done), 32'(out_done_res));
          check_field("read_data", 32'(want.rdata), 32'(out_read_data));
          check_field("status", 32'(want.status), 32'(out_status));
        end
      end
      if (in_valid && !in_stall)
        expected_lines.push_back(line_tick(in_mode, in_write_data, in_sda_in));
    end
    pending_results = expected_lines.size();
  end

endmodule

### dv/tb_i2c_master_bit_sequencer.sv
// testbench top for i2c_master_bit_sequencer: clock, reset, tick stimulus, register writes
// and verdict; depends on i2cbs_pkg, i2c_line_checker and the rtl
`timescale 1ns / 100ps

module tb_i2c_master_bit_sequencer;
  import i2cbs_pkg::*;

  typedef enum logic [1:0] {SDA_RANDOM, SDA_HIGH, SDA_LOW} sda_kind_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [2:0]           in_mode;
  logic [DATA_BITS-1:0] in_write_data;
  logic                 in_sda_in;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_scl_out;
  logic                 out_sda_out;
  logic                 out_busy_res;
  logic                 out_done_res;
  logic [DATA_BITS-1:0] out_read_data;
  logic [1:0]           out_status;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  int mismatches;
  int pending_results;
  int accepted;
  int results;
  int dones;
  int cmds;
  int settings;
  int start_fails;
  int no_acks;
  int hold_left;
  bit gaps_on;
  bit hold_req;

  i2c_master_bit_sequencer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_write_data(in_write_data), .in_sda_in(in_sda_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_scl_out(out_scl_out),
    .out_sda_out(out_sda_out), .out_busy_res(out_busy_res), .out_done_res(out_done_res),
    .out_read_data(out_read_data), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  i2c_line_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_write_data(in_write_data), .in_sda_in(in_sda_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_scl_out(out_scl_out),
    .out_sda_out(out_sda_out), .out_busy_res(out_busy_res), .out_done_res(out_done_res),
    .out_read_data(out_read_data), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatches(mismatches), .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver side: random stalls, quiet stretches and one long hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 400;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!gaps_on) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 20);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results++;
      if (out_done_res) begin
        dones++;
        if (out_status == ST_START_FL) start_fails++;
        if (out_status == ST_NO_ACK) no_acks++;
      end
    end
  end

  function automatic logic pick_sda(input sda_kind_t kind);
    if (kind == SDA_HIGH) return 1'b1;
    if (kind == SDA_LOW) return 1'b0;
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic sda_kind_t ack_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return SDA_LOW;
    if (r < 85) return SDA_HIGH;
    return SDA_RANDOM;
  endfunction

  function automatic sda_kind_t read_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return SDA_RANDOM;
    if (r < 85) return SDA_HIGH;
    return SDA_LOW;
  endfunction

  task automatic drive_tick(input logic [2:0] op, input logic [DATA_BITS-1:0] data,
                            input logic sda);
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= op;
    in_write_data <= data;
    in_sda_in     <= sda;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accepted++;
  endtask

  // issue one command, then mostly idle ticks until its done comes back
  task automatic run_command(input logic [2:0] op, input logic [DATA_BITS-1:0] data,
                             input sda_kind_t kind);
    logic [2:0] filler;
    bit         first;
    drive_tick(op, data, pick_sda(kind));
    cmds++;
    first = 1'b1;
    while (dones < cmds) begin
      filler = MODE_NONE;
      // the tick after a command is always busy, so a command there is ignored
      if (first && $urandom_range(0, 99) < 30) filler = 3'($urandom_range(1, 7));
      drive_tick(filler, 8'($urandom_range(0, 255)), pick_sda(kind));
      first = 1'b0;
    end
  endtask

  task automatic random_cmds(input int n);
    int                   stop_at;
    int                   nbytes;
    int                   k;
    logic [DATA_BITS-1:0] addr;
    stop_at = cmds + n;
    while (cmds < stop_at) begin
      if ($urandom_range(0, 99) < 75) begin
        addr   = 8'($urandom_range(0, 255));
        nbytes = $urandom_range(0, 3);
        run_command(MODE_START, addr, SDA_RANDOM);
        run_command(MODE_WRITE, addr, SDA_RANDOM);
        run_command(MODE_WACK, addr, ack_kind());
        for (k = 0; k < nbytes; k++) begin
          if (addr[0]) begin
            run_command(MODE_READ, 8'($urandom_range(0, 255)), read_kind());
            if (k == nbytes - 1)
              run_command(MODE_NACK, 8'($urandom_range(0, 255)), SDA_RANDOM);
            else
              run_command(MODE_ACK, 8'($urandom_range(0, 255)), SDA_RANDOM);
          end else begin
            run_command(MODE_WRITE, 8'($urandom_range(0, 255)), SDA_RANDOM);
            run_command(MODE_WACK, 8'($urandom_range(0, 255)), ack_kind());
          end
        end
        if ($urandom_range(0, 99) < 90)
          run_command(MODE_STOP, 8'($urandom_range(0, 255)), SDA_RANDOM);
      end else begin
        run_command(3'($urandom_range(1, 7)), 8'($urandom_range(0, 255)),
                    sda_kind_t'($urandom_range(0, 2)));
      end
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (results == accepted);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_regs(input logic [HP_W-1:0] hp, input logic [POLL_W-1:0] pl);
    settle();
    reg_access(1'b1, {REG_HALF_PERIOD, 2'b00}, {16'h0, hp});
    reg_access(1'b1, {REG_POLL_LIMIT, 2'b00}, {24'h0, pl});
    reg_access(1'b0, {REG_HALF_PERIOD, 2'b00}, 32'h0);
    reg_access(1'b0, {REG_POLL_LIMIT, 2'b00}, 32'h0);
    settings++;
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = MODE_NONE;
    in_write_data = '0;
    in_sda_in     = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    gaps_on       = 1'b1;
    hold_req      = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset register values, then one acknowledged wait-ack at the reset half period
    reg_access(1'b0, {REG_HALF_PERIOD, 2'b00}, 32'h0);
    reg_access(1'b0, {REG_POLL_LIMIT, 2'b00}, 32'h0);
    run_command(MODE_WACK, 8'h00, SDA_LOW);

    // every command, byte extremes, ack and nack, both start failures
    program_regs(16'd1, 8'd2);
    run_command(MODE_START, 8'h00, SDA_RANDOM);
    run_command(MODE_WRITE, 8'h00, SDA_RANDOM);
    run_command(MODE_WACK, 8'h00, SDA_LOW);
    run_command(MODE_WRITE, 8'hFF, SDA_RANDOM);
    run_command(MODE_WACK, 8'hFF, SDA_HIGH);
    run_command(MODE_READ, 8'h00, SDA_HIGH);
    run_command(MODE_ACK, 8'h00, SDA_RANDOM);
    run_command(MODE_READ, 8'hFF, SDA_LOW);
    run_command(MODE_ACK, 8'hFF, SDA_RANDOM);
    run_command(MODE_READ, 8'h5A, SDA_RANDOM);
    run_command(MODE_NACK, 8'h00, SDA_RANDOM);
    run_command(MODE_STOP, 8'h00, SDA_RANDOM);
    run_command(MODE_START, 8'h00, SDA_LOW);
    run_command(MODE_START, 8'h00, SDA_HIGH);
    run_command(MODE_WRITE, 8'hA5, SDA_RANDOM);
    run_command(MODE_STOP, 8'hFF, SDA_RANDOM);

    // zero half period and zero poll limit
    program_regs(16'd0, 8'd0);
    run_command(MODE_START, 8'h00, SDA_LOW);
    run_command(MODE_START, 8'h00, SDA_HIGH);
    run_command(MODE_START, 8'h00, SDA_RANDOM);
    run_command(MODE_WRITE, 8'h3C, SDA_RANDOM);
    run_command(MODE_STOP, 8'h00, SDA_RANDOM);
    random_cmds(20);

    program_regs(16'd1, 8'd1);
    hold_req = 1'b1;
    random_cmds(20);

    program_regs(16'd2, 8'd255);
    gaps_on = 1'b0;
    random_cmds(14);
    gaps_on = 1'b1;

    program_regs(16'd3, 8'd2);
    random_cmds(6);

    program_regs(16'd1, 8'd249);
    random_cmds(10);

    program_regs(16'd5, 8'd3);
    random_cmds(3);

    program_regs(16'd2, 8'd1);
    random_cmds(8);

    settle();
    repeat (20) @(posedge clk);
    $display("run covered %0d ticks and %0d commands under %0d register settings",
             accepted, cmds, settings + 1);
    $display("outcomes seen: %0d failed starts, %0d missing acknowledges",
             start_fails, no_acks);
    if (mismatches == 0 && pending_results == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout after %0d ticks, %0d results", accepted, results);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### sim.f
rtl/i2cbs_pkg.sv
rtl/i2cbs_cfg.sv
rtl/i2cbs_core.sv
rtl/i2c_master_bit_sequencer.sv
dv/i2c_line_checker.sv
dv/tb_i2c_master_bit_sequencer.sv
